// ===== src/ramon_pkg.sv =====
// ----------------------------------------------------------------------------
// ramon_pkg
// Types and constants shared by the range alarm monitor modules.
// ----------------------------------------------------------------------------
package ramon_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned StampW    = 32;
  localparam int unsigned SumW      = SampleW + 1;
  localparam int unsigned CountW    = 8;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned LimitW    = IntervalW + CountW;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 2 * SampleW + 3 * StampW;
  localparam int unsigned OutDataW  = ((SumW + 7) / 8) * 8;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ALERT_TIMEOUT = 2'd0,
    ALERT_WARNING = 2'd1,
    ALERT_RESUMED = 2'd2
  } alert_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_LEVEL     = 3'd0,
    CFG_MAX_LEVEL     = 3'd1,
    CFG_WARNING_COUNT = 3'd2,
    CFG_RESUME_COUNT  = 3'd3,
    CFG_POLL_INTERVAL = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] min_level;
    logic signed [SampleW-1:0] max_level;
    logic [CountW-1:0]         warning_count;
    logic [CountW-1:0]         resume_count;
    logic [IntervalW-1:0]      poll_interval;
  } cfg_t;

  typedef struct packed {
    logic              normal_flag;
    logic [CountW-1:0] out_range_ticks;
    logic [CountW-1:0] in_range_ticks;
  } mon_state_t;

  // Listed from the highest bits down, so sample_a sits in the lowest bits.
  typedef struct packed {
    logic [StampW-1:0]         now_time;
    logic [StampW-1:0]         stamp_b;
    logic [StampW-1:0]         stamp_a;
    logic signed [SampleW-1:0] sample_b;
    logic signed [SampleW-1:0] sample_a;
  } poll_t;

  localparam cfg_t CfgReset = '{
    min_level:     32'sd0,
    max_level:     32'sd2147483647,
    warning_count: 8'd3,
    resume_count:  8'd3,
    poll_interval: 16'd60
  };

endpackage

// ===== src/ramon_eval.sv =====
// ----------------------------------------------------------------------------
// ramon_eval
// Judges one poll against the window and the timeout limit and gives the
// next monitor state and the alert, if any.
// ----------------------------------------------------------------------------
module ramon_eval (
  input  ramon_pkg::cfg_t       cfg_i,
  input  ramon_pkg::mon_state_t state_i,
  input  ramon_pkg::poll_t      poll_i,
  output ramon_pkg::mon_state_t state_o,
  output logic                  fire_o,
  output ramon_pkg::alert_kind_e kind_o,
  output logic signed [ramon_pkg::SumW-1:0] sum_o
);
  import ramon_pkg::*;

  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  lo_lim;
  logic signed [SumW-1:0]  hi_lim;
  logic                    out_of_range;
  logic [StampW-1:0]       mean_time;
  logic signed [StampW+1:0] elapsed;
  logic [LimitW-1:0]       limit;
  logic                    timed_out;
  logic [CountW-1:0]       out_cnt;
  logic [CountW-1:0]       in_cnt;

  assign sum    = SumW'(poll_i.sample_a) + SumW'(poll_i.sample_b);
  assign lo_lim = {cfg_i.min_level, 1'b0};
  assign hi_lim = {cfg_i.max_level, 1'b0};
  assign out_of_range = (sum < lo_lim) || (sum > hi_lim);

  assign mean_time = {1'b0, poll_i.stamp_a[StampW-1:1]} + {1'b0, poll_i.stamp_b[StampW-1:1]};
  assign elapsed   = $signed({2'b00, poll_i.now_time}) - $signed({2'b00, mean_time});
  assign limit     = LimitW'(cfg_i.poll_interval) * LimitW'(cfg_i.warning_count);
  assign timed_out = elapsed > $signed({{(StampW + 2 - LimitW){1'b0}}, limit});

  always_comb begin
    out_cnt = state_i.out_range_ticks;
    in_cnt  = state_i.in_range_ticks;
    if (out_of_range) begin
      if (out_cnt != CountMax) out_cnt = out_cnt + 1'b1;
    end else begin
      if (in_cnt != CountMax) in_cnt = in_cnt + 1'b1;
    end

    state_o = '{normal_flag: state_i.normal_flag, out_range_ticks: out_cnt,
                in_range_ticks: in_cnt};
    fire_o  = 1'b0;
    kind_o  = ALERT_TIMEOUT;
    if (state_i.normal_flag) begin
      if (timed_out) begin
        fire_o = 1'b1;
        kind_o = ALERT_TIMEOUT;
      end else if (out_cnt >= cfg_i.warning_count) begin
        fire_o = 1'b1;
        kind_o = ALERT_WARNING;
      end
      if (fire_o) begin
        state_o = '{normal_flag: 1'b0, out_range_ticks: '0, in_range_ticks: '0};
      end
    end else if (in_cnt >= cfg_i.resume_count) begin
      fire_o  = 1'b1;
      kind_o  = ALERT_RESUMED;
      state_o = '{normal_flag: 1'b1, out_range_ticks: '0, in_range_ticks: '0};
    end
  end

  assign sum_o = sum;

endmodule

// ===== src/range_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// range_alarm_monitor
// An item is registered at the input, judged from the input register and its
// alert, if any, is registered at the output and shown from there.
// Throughput: one item per cycle, stalled only while the output holds an
// untaken alert and the input register is full.
// Reset clears the monitor state to normal with both counters at zero and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module range_alarm_monitor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ramon_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ramon_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // sample_a, sample_b, stamp_a, stamp_b, now_time
  input  logic [ramon_pkg::InDataW-1:0]     s_axis_tdata_i,
  // have_two
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // pair_sum, zero fill
  output logic [ramon_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // alert_kind
  output logic [1:0]                        m_axis_tuser_o
);
  import ramon_pkg::*;

  cfg_t        cfg_q;
  mon_state_t  state_q, state_d;
  logic        in_valid_q;
  poll_t       poll_q;
  logic        out_valid_q;
  alert_kind_e kind_q, kind_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic        fire;
  logic        advance;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_LEVEL:     cfg_q.min_level     <= $signed(cfg_data_i);
        CFG_MAX_LEVEL:     cfg_q.max_level     <= $signed(cfg_data_i);
        CFG_WARNING_COUNT: cfg_q.warning_count <= cfg_data_i[CountW-1:0];
        CFG_RESUME_COUNT:  cfg_q.resume_count  <= cfg_data_i[CountW-1:0];
        CFG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_data_i[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  ramon_eval u_eval (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .poll_i  (poll_q),
    .state_o (state_d),
    .fire_o  (fire),
    .kind_o  (kind_d),
    .sum_o   (sum_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i && s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      poll_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{normal_flag: 1'b1, out_range_ticks: '0, in_range_ticks: '0};
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && fire;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      kind_q <= kind_d;
      sum_q  <= sum_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - SumW){1'b0}}, sum_q};
  assign m_axis_tuser_o  = kind_q;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives poll items into the range alarm monitor and checks every alert it
// raises. A directed table covers the sample and time extremes, the window
// edges, every alert kind, time running back and ticks without samples.
// Random phases follow, each with its own register setting, among them an
// inverted window, the widest window and the extreme counts. Every accepted
// item goes through a predictor of the monitor state, and each alert is
// compared with the oldest expected one. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ramon_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseCount    = 13;
  localparam int PhaseItems    = 141;

  typedef struct packed {
    bit                        have_two;
    logic signed [SampleW-1:0] sample_a;
    logic signed [SampleW-1:0] sample_b;
    logic [StampW-1:0]         stamp_a;
    logic [StampW-1:0]         stamp_b;
    logic [StampW-1:0]         now_time;
  } poll_item_t;

  typedef struct packed {
    alert_kind_e            kind;
    logic signed [SumW-1:0] pair_sum;
  } alert_t;

  typedef struct packed {
    poll_item_t item;
    bit         typed;
    bit         fires;
    alert_t     alert;
  } poll_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic [InDataW-1:0]   s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic [1:0]           m_axis_tuser_o;

  range_alarm_monitor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cfg_t              live_cfg = CfgReset;
  bit                is_normal = 1'b1;
  logic [CountW-1:0] out_ticks = '0;
  logic [CountW-1:0] in_ticks = '0;
  alert_t            alerts_due[$];
  poll_row_t         pending_polls[$];
  poll_row_t         directed_rows[$];
  bit                pacing_on = 1'b1;
  int                mismatches = 0;
  int                quiet_cycles = 0;

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Advances the monitor state by one poll and returns whether it alerts.
  function automatic bit judge_poll(input poll_item_t p, output alert_t a);
    longint      sum;
    longint      mean_time;
    longint      elapsed;
    longint      limit;
    bit          off_window;
    bit          fire;
    alert_kind_e kind;
    fire = 1'b0;
    kind = ALERT_TIMEOUT;
    a.kind = ALERT_TIMEOUT;
    a.pair_sum = '0;
    if (!p.have_two) begin
      return 1'b0;
    end
    sum = longint'($signed(p.sample_a)) + longint'($signed(p.sample_b));
    mean_time = longint'({32'd0, p.stamp_a >> 1}) + longint'({32'd0, p.stamp_b >> 1});
    elapsed = longint'({32'd0, p.now_time}) - mean_time;
    limit = longint'({48'd0, live_cfg.poll_interval}) *
            longint'({56'd0, live_cfg.warning_count});
    off_window = (sum < 2 * longint'($signed(live_cfg.min_level))) ||
                 (sum > 2 * longint'($signed(live_cfg.max_level)));
    if (off_window) begin
      if (out_ticks != CountMax) out_ticks++;
    end else begin
      if (in_ticks != CountMax) in_ticks++;
    end
    if (is_normal) begin
      if (elapsed > limit) begin
        fire = 1'b1;
        kind = ALERT_TIMEOUT;
      end else if (out_ticks >= live_cfg.warning_count) begin
        fire = 1'b1;
        kind = ALERT_WARNING;
      end
      if (fire) begin
        is_normal = 1'b0;
        out_ticks = '0;
        in_ticks = '0;
      end
    end else if (in_ticks >= live_cfg.resume_count) begin
      fire = 1'b1;
      kind = ALERT_RESUMED;
      is_normal = 1'b1;
      out_ticks = '0;
      in_ticks = '0;
    end
    a.kind = kind;
    a.pair_sum = sum[SumW-1:0];
    return fire;
  endfunction

  function automatic logic signed [SampleW-1:0] pick_level();
    longint lo;
    longint hi;
    lo = longint'($signed(live_cfg.min_level));
    hi = longint'($signed(live_cfg.max_level));
    if (lo > hi) begin
      return $urandom();
    end
    return SampleW'(lo + longint'({32'd0, $urandom()}) % (hi - lo + 1));
  endfunction

  function automatic poll_item_t make_poll();
    poll_item_t p;
    int unsigned pick;
    longint      mean_time;
    longint      limit;
    longint      delta;
    pick = $urandom_range(0, 99);
    p.have_two = 1'b1;
    p.sample_a = $urandom();
    p.sample_b = $urandom();
    p.stamp_a = $urandom();
    p.stamp_b = $urandom();
    p.now_time = $urandom();
    if (pick < 8) begin
      p.have_two = 1'b0;
    end else if (pick >= 18) begin
      if ($urandom_range(0, 1) == 1) begin
        p.sample_a = pick_level();
        p.sample_b = pick_level();
      end else if ($urandom_range(0, 1) == 1) begin
        p.sample_a = pick_level();
      end
      p.stamp_b = p.stamp_a + $urandom_range(0, 1000);
      mean_time = longint'({32'd0, p.stamp_a >> 1}) + longint'({32'd0, p.stamp_b >> 1});
      limit = longint'({48'd0, live_cfg.poll_interval}) *
              longint'({56'd0, live_cfg.warning_count});
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        delta = longint'($urandom_range(0, 32'(limit)));
      end else if (pick < 88) begin
        delta = limit;
      end else if (pick < 95) begin
        delta = limit + longint'($urandom_range(1, 2));
      end else begin
        delta = -longint'($urandom_range(1, 1000));
      end
      p.now_time = StampW'(mean_time + delta);
    end
    return p;
  endfunction

  function automatic cfg_t pick_config(input int phase);
    cfg_t c;
    logic signed [SampleW-1:0] t;
    c.min_level = $urandom();
    c.max_level = $urandom();
    if ($urandom_range(0, 99) < 85 && c.min_level > c.max_level) begin
      t = c.min_level;
      c.min_level = c.max_level;
      c.max_level = t;
    end
    if ($urandom_range(0, 99) < 30) begin
      t = c.min_level + $signed(SampleW'($urandom_range(0, 500)));
      c.max_level = (t < c.min_level) ? 32'sh7fff_ffff : t;
    end
    c.warning_count = ($urandom_range(0, 99) < 70) ? CountW'($urandom_range(1, 6)) :
                      CountW'($urandom_range(1, 255));
    c.resume_count = ($urandom_range(0, 99) < 70) ? CountW'($urandom_range(1, 6)) :
                     CountW'($urandom_range(1, 255));
    c.poll_interval = IntervalW'($urandom_range(1, 65535));
    case (phase)
      1: begin
        c.min_level = 32'sd100;
        c.max_level = -32'sd100;
        c.warning_count = 8'd2;
        c.resume_count = 8'd2;
        c.poll_interval = 16'd60;
      end
      2: begin
        c.min_level = 32'sh8000_0000;
        c.max_level = 32'sh7fff_ffff;
        c.warning_count = 8'd255;
        c.resume_count = 8'd255;
        c.poll_interval = 16'hffff;
      end
      3: begin
        c.max_level = c.min_level;
        c.warning_count = 8'd1;
        c.resume_count = 8'd1;
        c.poll_interval = 16'd1;
      end
      4: begin
        c.min_level = 32'sh8000_0000;
        c.max_level = 32'sh8000_0000;
        c.warning_count = 8'd1;
        c.resume_count = 8'd255;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  task automatic put_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  task automatic set_config(input cfg_t c);
    put_reg(CFG_MIN_LEVEL, c.min_level);
    put_reg(CFG_MAX_LEVEL, c.max_level);
    put_reg(CFG_WARNING_COUNT, {24'd0, c.warning_count});
    put_reg(CFG_RESUME_COUNT, {24'd0, c.resume_count});
    put_reg(CFG_POLL_INTERVAL, {16'd0, c.poll_interval});
    cfg_we <= 1'b0;
    live_cfg = c;
  endtask

  task automatic drive_poll(input poll_row_t r);
    int gap;
    gap = pacing_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pending_polls.push_back(r);
    s_tvalid <= 1'b1;
    s_tuser <= r.item.have_two;
    s_tdata <= {r.item.now_time, r.item.stamp_b, r.item.stamp_a,
                r.item.sample_b, r.item.sample_a};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Called right after the last item was accepted; lets the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (alerts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_row(input bit have, input int a, input int b, input int unsigned sa,
                         input int unsigned sb, input int unsigned now, input bit typed,
                         input bit fires, input alert_kind_e kind, input longint sum);
    poll_row_t r;
    r.item.have_two = have;
    r.item.sample_a = a;
    r.item.sample_b = b;
    r.item.stamp_a = sa;
    r.item.stamp_b = sb;
    r.item.now_time = now;
    r.typed = typed;
    r.fires = fires;
    r.alert.kind = kind;
    r.alert.pair_sum = sum[SumW-1:0];
    directed_rows.push_back(r);
  endtask

  always @(posedge clk_i) begin
    poll_row_t r;
    alert_t    fresh;
    bit        fired;
    if (rst_ni && s_tvalid && s_axis_tready_o) begin
      r = pending_polls.pop_front();
      fired = judge_poll(r.item, fresh);
      if (r.typed) begin
        if (r.fires) alerts_due.push_back(r.alert);
      end else if (fired) begin
        alerts_due.push_back(fresh);
      end
    end
  end

  always @(posedge clk_i) begin
    alert_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (alerts_due.size() == 0) begin
        flag_error($sformatf("unexpected alert: kind %0d data %h",
                             m_axis_tuser_o, m_axis_tdata_o));
      end else begin
        want = alerts_due.pop_front();
        if (m_axis_tuser_o !== want.kind ||
            m_axis_tdata_o !== {{(OutDataW - SumW){1'b0}}, want.pair_sum}) begin
          flag_error($sformatf("alert mismatch: expected kind %0d sum %0d, got kind %0d data %h",
                               want.kind, want.pair_sum, m_axis_tuser_o, m_axis_tdata_o));
        end
      end
    end
  end

  initial begin
    int gap;
    forever begin
      gap = pacing_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (s_tvalid && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    poll_row_t r;
    // The reset window is [0, max], both counts are 3 and the time limit is 180.
    add_row(0, 32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff, 32'hffff_ffff,
            1, 0, ALERT_TIMEOUT, 0);
    add_row(1, 10, 20, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, -1, -1, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 32'h8000_0000, 32'h8000_0000, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 32'h7fff_ffff, 32'h7fff_ffff, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 32'h7fff_ffff, 32'h8000_0000, 1000, 1000, 1000, 1, 1, ALERT_WARNING, -1);
    add_row(1, 0, 0, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 1, -1, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 5, 7, 0, 0, 32'hffff_ffff, 1, 1, ALERT_RESUMED, 12);
    add_row(1, -7, 3, 0, 0, 181, 1, 1, ALERT_TIMEOUT, -4);
    add_row(0, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f,
            1, 0, ALERT_TIMEOUT, 0);
    add_row(1, 100, 200, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 100, 200, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 100, 200, 32'hffff_ffff, 32'hffff_ffff, 0, 1, 1, ALERT_RESUMED, 300);
    add_row(1, 100, 200, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 0, 0, 2, 2, 182, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 0, 0, 3, 3, 183, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 32'h8000_0000, -1, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);
    add_row(1, 32'h7fff_ffff, 1, 1000, 1000, 1000, 0, 0, ALERT_TIMEOUT, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_poll(directed_rows[i]);
    end
    wait_idle();

    for (int phase = 1; phase <= PhaseCount; phase++) begin
      pacing_on = ($urandom_range(0, 3) != 0);
      set_config(pick_config(phase));
      repeat (PhaseItems) begin
        r = '0;
        r.item = make_poll();
        drive_poll(r);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && alerts_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
